// File: src/rrp_pkg.sv
package rrp_pkg;

    typedef enum logic [3:0] {
        PH_TYPE  = 4'd0,
        PH_LINE  = 4'd1,
        PH_INT   = 4'd2,
        PH_BLEN  = 4'd3,
        PH_BDATA = 4'd4,
        PH_ALEN  = 4'd5,
        PH_ETYPE = 4'd6,
        PH_ELINE = 4'd7,
        PH_IDLE  = 4'd8
    } phase_t;

    localparam logic [2:0] KIND_LINE  = 3'd0;
    localparam logic [2:0] KIND_ELEM  = 3'd1;
    localparam logic [2:0] KIND_INT   = 3'd2;
    localparam logic [2:0] KIND_BLEN  = 3'd3;
    localparam logic [2:0] KIND_NIL   = 3'd4;
    localparam logic [2:0] KIND_ACNT  = 3'd5;
    localparam logic [2:0] KIND_ERROR = 3'd6;

    localparam logic [2:0] RT_ERROR   = 3'd0;
    localparam logic [2:0] RT_STATUS  = 3'd1;
    localparam logic [2:0] RT_INTEGER = 3'd2;
    localparam logic [2:0] RT_BULK    = 3'd3;
    localparam logic [2:0] RT_ARRAY   = 3'd4;
    localparam logic [2:0] RT_UNKNOWN = 3'd5;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_TYPE   = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;
    localparam logic [1:0] ERR_SYNTAX = 2'd3;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [0:0] IDX_MAX_BULK = 1'b0;
    localparam logic [0:0] IDX_MAX_ELEM = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  reply_type;
        logic [7:0]  payload_byte;
        logic [63:0] number;
        logic [30:0] element_index;
        logic        element_end;
        logic        reply_done;
        logic [1:0]  error_code;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_reply;
    } byte_t;

endpackage

// File: src/rrp_if.sv
interface rrp_in_if
    import rrp_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrp_out_if
    import rrp_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/rrp_fifo.sv
module rrp_fifo
    import rrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    pop_valid,
    input  logic    pop,
    output result_t pop_data
);
    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && pop_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop && pop_valid};
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count invalid");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_valid && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue pop lost");
`endif
endmodule

// File: src/rrp_parser.sv
module rrp_parser
    import rrp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  byte_t       in_data,
    output logic        in_ready,
    input  logic [30:0] max_bulk_len,
    input  logic [30:0] max_elements,
    output logic        res_push,
    output result_t     res_data,
    input  logic        res_full
);
    localparam logic [COUNT_WIDTH-1:0] CAP = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LIM_Q_POS = POS_LIM / 64'd10;
    localparam logic [63:0] LIM_Q_NEG = NEG_LIM / 64'd10;
    localparam logic [3:0]  LIM_R_POS = 4'(POS_LIM % 64'd10);
    localparam logic [3:0]  LIM_R_NEG = 4'(NEG_LIM % 64'd10);

    phase_t                 phase_reg, phase_next;
    logic [2:0]             type_reg, type_next;
    logic [63:0]            acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   cr_reg, cr_next;
    logic                   arr_reg, arr_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] done_reg, done_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic                   fin_reg, fin_next;
    logic                   held_v_reg, held_v_next;
    logic [7:0]             held_reg, held_next;
    logic                   dig_reg, dig_next;

    logic [COUNT_WIDTH-1:0] bulk_cap, elem_cap;
    logic [7:0]             b;
    logic                   emit;
    result_t                r;
    logic                   take;
    logic [3:0]             d;
    logic                   is_digit;
    logic                   overflow;
    logic                   last;
    logic [63:0]            acc_x10;
    logic [COUNT_WIDTH:0]   done_inc;

    assign in_ready = !res_full;
    assign take     = in_valid && in_ready;
    assign b        = in_data.data_byte;
    assign res_push = take && emit;
    assign res_data = r;

    always_comb
    begin
        bulk_cap = ({1'b0, max_bulk_len} < 32'(CAP)) ? COUNT_WIDTH'(max_bulk_len) : CAP;
        elem_cap = ({1'b0, max_elements} < 32'(CAP)) ? COUNT_WIDTH'(max_elements) : CAP;
    end

    always_comb
    begin
        d        = b[3:0];
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        acc_x10  = (acc_reg << 3) + (acc_reg << 1);
        if (neg_reg)
        begin
            overflow = (acc_reg > LIM_Q_NEG) || ((acc_reg == LIM_Q_NEG) && (d > LIM_R_NEG));
        end
        else
        begin
            overflow = (acc_reg > LIM_Q_POS) || ((acc_reg == LIM_Q_POS) && (d > LIM_R_POS));
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        cr_next     = cr_reg;
        arr_next    = arr_reg;
        total_next  = total_reg;
        done_next   = done_reg;
        rem_next    = rem_reg;
        fin_next    = fin_reg;
        held_v_next = held_v_reg;
        held_next   = held_reg;
        dig_next    = dig_reg;
        if (in_data.start_of_reply)
        begin
            phase_next  = PH_TYPE;
            type_next   = RT_ERROR;
            acc_next    = '0;
            neg_next    = 1'b0;
            cr_next     = 1'b0;
            arr_next    = 1'b0;
            total_next  = '0;
            done_next   = '0;
            rem_next    = '0;
            fin_next    = 1'b0;
            held_v_next = 1'b0;
            held_next   = '0;
            dig_next    = 1'b0;
        end
        emit             = 1'b0;
        r                = '0;
        done_inc         = {1'b0, done_next} + 1'b1;
        last             = !arr_next || (done_inc >= {1'b0, total_next});
        r.element_index  = arr_next ? 31'(done_next) : 31'd0;

        if (!fin_next)
        begin
            case (phase_next)
                PH_TYPE:
                begin
                    if (b == CH_MINUS || b == CH_PLUS)
                    begin
                        type_next   = (b == CH_MINUS) ? RT_ERROR : RT_STATUS;
                        phase_next  = PH_LINE;
                        cr_next     = 1'b0;
                        held_v_next = 1'b0;
                    end
                    else if (b == CH_COLON || b == CH_DOLLAR || b == CH_STAR)
                    begin
                        type_next  = (b == CH_COLON) ? RT_INTEGER :
                                     (b == CH_DOLLAR) ? RT_BULK : RT_ARRAY;
                        phase_next = (b == CH_COLON) ? PH_INT :
                                     (b == CH_DOLLAR) ? PH_BLEN : PH_ALEN;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        dig_next   = 1'b0;
                        cr_next    = 1'b0;
                    end
                    else
                    begin
                        type_next  = RT_UNKNOWN;
                        emit       = 1'b1;
                        r.kind     = KIND_ERROR;
                        r.reply_done = 1'b1;
                        r.error_code = ERR_TYPE;
                    end
                end
                PH_LINE, PH_ELINE:
                begin
                    r.kind = (phase_next == PH_LINE) ? KIND_LINE : KIND_ELEM;
                    if (cr_next)
                    begin
                        emit = 1'b1;
                        if (b == CH_LF)
                        begin
                            r.payload_byte = held_v_next ? held_next : 8'd0;
                            r.number       = {63'd0, held_v_next};
                            r.element_end  = 1'b1;
                            r.reply_done   = last;
                            held_v_next    = 1'b0;
                            cr_next        = 1'b0;
                            if (!last)
                            begin
                                done_next  = done_inc[COUNT_WIDTH-1:0];
                                phase_next = PH_ETYPE;
                            end
                            else
                            begin
                                fin_next = 1'b1;
                            end
                        end
                        else
                        begin
                            r.kind       = KIND_ERROR;
                            r.reply_done = 1'b1;
                            r.error_code = ERR_SYNTAX;
                        end
                    end
                    else if (b == CH_CR)
                    begin
                        cr_next = 1'b1;
                    end
                    else if (b == CH_LF)
                    begin
                        emit         = 1'b1;
                        r.kind       = KIND_ERROR;
                        r.reply_done = 1'b1;
                        r.error_code = ERR_SYNTAX;
                    end
                    else
                    begin
                        if (held_v_next)
                        begin
                            emit           = 1'b1;
                            r.payload_byte = held_next;
                            r.number       = 64'd1;
                        end
                        held_next   = b;
                        held_v_next = 1'b1;
                    end
                end
                PH_INT, PH_BLEN, PH_ALEN:
                begin
                    if (cr_next)
                    begin
                        cr_next = 1'b0;
                        emit    = 1'b1;
                        if (b != CH_LF || !dig_next)
                        begin
                            r.kind       = KIND_ERROR;
                            r.reply_done = 1'b1;
                            r.error_code = ERR_SYNTAX;
                        end
                        else if (phase_next == PH_INT)
                        begin
                            r.kind        = KIND_INT;
                            r.number      = neg_next ? (64'd0 - acc_next) : acc_next;
                            r.element_end = 1'b1;
                            r.reply_done  = 1'b1;
                            fin_next      = 1'b1;
                        end
                        else if (neg_next)
                        begin
                            if (acc_next != 64'd1)
                            begin
                                r.kind       = KIND_ERROR;
                                r.reply_done = 1'b1;
                                r.error_code = ERR_RANGE;
                            end
                            else if (phase_next == PH_BLEN)
                            begin
                                r.kind        = KIND_NIL;
                                r.number      = '1;
                                r.element_end = 1'b1;
                                r.reply_done  = last;
                                if (!last)
                                begin
                                    done_next  = done_inc[COUNT_WIDTH-1:0];
                                    phase_next = PH_ETYPE;
                                end
                                else
                                begin
                                    fin_next = 1'b1;
                                end
                            end
                            else
                            begin
                                r.kind       = KIND_ACNT;
                                r.number     = '1;
                                r.reply_done = 1'b1;
                                fin_next     = 1'b1;
                            end
                        end
                        else if (phase_next == PH_BLEN)
                        begin
                            if (acc_next > 64'(bulk_cap))
                            begin
                                r.kind       = KIND_ERROR;
                                r.reply_done = 1'b1;
                                r.error_code = ERR_RANGE;
                            end
                            else
                            begin
                                r.kind      = KIND_BLEN;
                                r.number    = acc_next;
                                rem_next    = acc_next[COUNT_WIDTH-1:0];
                                phase_next  = PH_BDATA;
                                held_v_next = 1'b0;
                            end
                        end
                        else
                        begin
                            if (acc_next > 64'(elem_cap))
                            begin
                                r.kind       = KIND_ERROR;
                                r.reply_done = 1'b1;
                                r.error_code = ERR_RANGE;
                            end
                            else if (acc_next == 64'd0)
                            begin
                                r.kind       = KIND_ACNT;
                                r.reply_done = 1'b1;
                                fin_next     = 1'b1;
                            end
                            else
                            begin
                                r.kind     = KIND_ACNT;
                                r.number   = acc_next;
                                total_next = acc_next[COUNT_WIDTH-1:0];
                                done_next  = '0;
                                arr_next   = 1'b1;
                                phase_next = PH_ETYPE;
                            end
                        end
                    end
                    else if (b == CH_CR)
                    begin
                        cr_next = 1'b1;
                    end
                    else if (b == CH_MINUS && !dig_next && !neg_next)
                    begin
                        neg_next = 1'b1;
                    end
                    else if (is_digit)
                    begin
                        if (overflow)
                        begin
                            emit         = 1'b1;
                            r.kind       = KIND_ERROR;
                            r.reply_done = 1'b1;
                            r.error_code = ERR_RANGE;
                        end
                        else
                        begin
                            acc_next = acc_x10 + {60'd0, d};
                            dig_next = 1'b1;
                        end
                    end
                    else
                    begin
                        emit         = 1'b1;
                        r.kind       = KIND_ERROR;
                        r.reply_done = 1'b1;
                        r.error_code = ERR_SYNTAX;
                    end
                end
                PH_BDATA:
                begin
                    r.kind = KIND_ELEM;
                    if (rem_next != '0)
                    begin
                        rem_next = rem_next - 1'b1;
                        if (held_v_next)
                        begin
                            emit           = 1'b1;
                            r.payload_byte = held_next;
                            r.number       = 64'd1;
                        end
                        held_next   = b;
                        held_v_next = 1'b1;
                    end
                    else if (!cr_next)
                    begin
                        if (b != CH_CR)
                        begin
                            emit         = 1'b1;
                            r.kind       = KIND_ERROR;
                            r.reply_done = 1'b1;
                            r.error_code = ERR_SYNTAX;
                        end
                        else
                        begin
                            cr_next = 1'b1;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (b != CH_LF)
                        begin
                            r.kind       = KIND_ERROR;
                            r.reply_done = 1'b1;
                            r.error_code = ERR_SYNTAX;
                        end
                        else
                        begin
                            r.payload_byte = held_v_next ? held_next : 8'd0;
                            r.number       = {63'd0, held_v_next};
                            r.element_end  = 1'b1;
                            r.reply_done   = last;
                            held_v_next    = 1'b0;
                            cr_next        = 1'b0;
                            if (!last)
                            begin
                                done_next  = done_inc[COUNT_WIDTH-1:0];
                                phase_next = PH_ETYPE;
                            end
                            else
                            begin
                                fin_next = 1'b1;
                            end
                        end
                    end
                end
                PH_ETYPE:
                begin
                    if (b == CH_DOLLAR)
                    begin
                        phase_next = PH_BLEN;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        dig_next   = 1'b0;
                        cr_next    = 1'b0;
                    end
                    else if (b == CH_MINUS || b == CH_PLUS || b == CH_COLON)
                    begin
                        phase_next  = PH_ELINE;
                        cr_next     = 1'b0;
                        held_next   = b;
                        held_v_next = 1'b1;
                    end
                    else
                    begin
                        emit         = 1'b1;
                        r.kind       = KIND_ERROR;
                        r.reply_done = 1'b1;
                        r.error_code = ERR_TYPE;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
            if (emit && r.kind == KIND_ERROR)
            begin
                r.payload_byte = '0;
                r.number       = '0;
                r.element_end  = 1'b0;
                fin_next       = 1'b1;
            end
            if (fin_next)
            begin
                phase_next  = PH_IDLE;
                held_v_next = 1'b0;
            end
        end
        r.reply_type    = type_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            type_reg   <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            cr_reg     <= 1'b0;
            arr_reg    <= 1'b0;
            total_reg  <= '0;
            done_reg   <= '0;
            rem_reg    <= '0;
            fin_reg    <= 1'b0;
            held_v_reg <= 1'b0;
            held_reg   <= '0;
            dig_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            cr_reg     <= cr_next;
            arr_reg    <= arr_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
            rem_reg    <= rem_next;
            fin_reg    <= fin_next;
            held_v_reg <= held_v_next;
            held_reg   <= held_next;
            dig_reg    <= dig_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> phase_reg == PH_IDLE)
        else $error("finished reply not idle");
    a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
        arr_reg |-> done_reg < total_reg)
        else $error("element index past count");
    a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_data.reply_done) |=> fin_reg)
        else $error("done result without finish");
    a_no_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !held_v_reg)
        else $error("held byte after finish");
`endif
endmodule

// File: src/resp_reply_parser_unit.sv
// RESP2 reply parser: one reply byte is taken per cycle, back to back, and a
// result, when the byte gives one, is registered in and leaves from a two-entry
// queue; the per-byte phase update, incl. the decimal digit step, sets the
// one-cycle rate. Payload bytes leave one byte late so the last can carry
// element_end. Input stalls only while the result queue is full.
module resp_reply_parser_unit
    import rrp_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    rrp_in_if.sink      in_ch,
    rrp_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    logic [30:0] max_bulk_reg;
    logic [30:0] max_elem_reg;
    logic        push;
    result_t     push_data;
    logic        full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bulk_reg <= 31'd536870912;
            max_elem_reg <= 31'h7FFF_FFFF;
        end
        else if (cfg_we)
        begin
            if (cfg_index == IDX_MAX_BULK)
            begin
                max_bulk_reg <= cfg_data;
            end
            else
            begin
                max_elem_reg <= cfg_data;
            end
        end
    end

    rrp_parser #(.COUNT_WIDTH(COUNT_WIDTH)) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_ch.valid),
        .in_data      (in_ch.data),
        .in_ready     (in_ch.ready),
        .max_bulk_len (max_bulk_reg),
        .max_elements (max_elem_reg),
        .res_push     (push),
        .res_data     (push_data),
        .res_full     (full)
    );

    rrp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop_valid (out_ch.valid),
        .pop       (out_ch.ready),
        .pop_data  (out_ch.data)
    );
endmodule

// File: test/rrp_checker.sv
`timescale 1ns / 1ps

module rrp_checker
    import rrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rrp_in_if           in_ch,
    rrp_out_if          out_ch,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int COUNT_W = 32;

    logic [30:0] lim_bulk, lim_elem;
    phase_t      ph;
    logic [2:0]  rtype;
    logic [63:0] acc;
    logic        neg, saw_cr, in_arr, finished, held_v, digit_seen;
    logic [7:0]  held_b;
    logic [31:0] elem_total, elem_done, bulk_left;
    result_t     parsed_q[$];
    logic        got;
    result_t     res;

    function automatic logic [63:0] cap_of(logic [30:0] r);
        logic [63:0] c;
        c = (64'd1 << (COUNT_W - 1)) - 64'd1;
        return ({33'd0, r} < c) ? {33'd0, r} : c;
    endfunction

    task automatic clear_state();
        ph = PH_TYPE; rtype = RT_ERROR; acc = '0; neg = 0; saw_cr = 0; in_arr = 0;
        elem_total = 0; elem_done = 0; bulk_left = 0; finished = 0; held_v = 0;
        held_b = 0; digit_seen = 0;
    endtask

    task automatic put(logic [2:0] k, logic [7:0] p, logic [63:0] n, logic e, logic d,
                       logic [1:0] err);
        res.kind = k; res.reply_type = rtype; res.payload_byte = p; res.number = n;
        res.element_index = in_arr ? elem_done[30:0] : 31'd0;
        res.element_end = e; res.reply_done = d; res.error_code = err;
        got = 1;
    endtask

    task automatic finish_it();
        finished = 1; ph = PH_IDLE; held_v = 0;
    endtask

    task automatic abort(logic [1:0] code);
        put(KIND_ERROR, 8'd0, 64'd0, 0, 1, code);
        finish_it();
    endtask

    function automatic logic last_elem();
        return !in_arr || ({32'd0, elem_done} + 64'd1 >= {32'd0, elem_total});
    endfunction

    task automatic step_on(logic last);
        if (last)
            finish_it();
        else
        begin
            elem_done++;
            ph = PH_ETYPE;
        end
    endtask

    task automatic close_item(logic [2:0] k);
        logic last;
        last = last_elem();
        if (held_v)
            put(k, held_b, 64'd1, 1, last, ERR_NONE);
        else
            put(k, 8'd0, 64'd0, 1, last, ERR_NONE);
        held_v = 0; saw_cr = 0;
        step_on(last);
    endtask

    task automatic line_in(logic [7:0] b, logic [2:0] k);
        if (saw_cr)
        begin
            if (b == CH_LF)
                close_item(k);
            else
                abort(ERR_SYNTAX);
        end
        else if (b == CH_CR)
            saw_cr = 1;
        else if (b == CH_LF)
            abort(ERR_SYNTAX);
        else
        begin
            if (held_v)
                put(k, held_b, 64'd1, 0, 0, ERR_NONE);
            held_b = b; held_v = 1;
        end
    endtask

    // -1 pending, 0 complete, else error code
    function automatic int digit_in(logic [7:0] b);
        logic [63:0] d, lim;
        if (saw_cr)
        begin
            saw_cr = 0;
            return (b != CH_LF || !digit_seen) ? 3 : 0;
        end
        if (b == CH_CR)
        begin
            saw_cr = 1;
            return -1;
        end
        if (b == CH_MINUS && !digit_seen && !neg)
        begin
            neg = 1;
            return -1;
        end
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            d = {56'd0, b - CH_ZERO};
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            if (acc > (lim - d) / 10)
                return 2;
            acc = acc * 10 + d;
            digit_seen = 1;
            return -1;
        end
        return 3;
    endfunction

    task automatic start_number(phase_t p);
        ph = p; acc = 0; neg = 0; digit_seen = 0; saw_cr = 0;
    endtask

    task automatic parse_byte(byte_t it);
        logic [7:0] b;
        int r;
        logic last;
        b = it.data_byte;
        got = 0;
        if (it.start_of_reply)
            clear_state();
        if (finished)
            return;
        case (ph)
            PH_TYPE:
            begin
                if (b == CH_MINUS || b == CH_PLUS)
                begin
                    rtype = (b == CH_MINUS) ? RT_ERROR : RT_STATUS;
                    ph = PH_LINE; saw_cr = 0; held_v = 0;
                end
                else if (b == CH_COLON)
                begin
                    rtype = RT_INTEGER; start_number(PH_INT);
                end
                else if (b == CH_DOLLAR)
                begin
                    rtype = RT_BULK; start_number(PH_BLEN);
                end
                else if (b == CH_STAR)
                begin
                    rtype = RT_ARRAY; start_number(PH_ALEN);
                end
                else
                begin
                    rtype = RT_UNKNOWN; abort(ERR_TYPE);
                end
            end
            PH_LINE: line_in(b, KIND_LINE);
            PH_ELINE: line_in(b, KIND_ELEM);
            PH_INT:
            begin
                r = digit_in(b);
                if (r > 0)
                    abort(r[1:0]);
                else if (r == 0)
                begin
                    put(KIND_INT, 8'd0, neg ? -acc : acc, 1, 1, ERR_NONE);
                    finish_it();
                end
            end
            PH_BLEN:
            begin
                r = digit_in(b);
                if (r > 0)
                    abort(r[1:0]);
                else if (r == 0)
                begin
                    if (neg)
                    begin
                        if (acc != 1)
                            abort(ERR_RANGE);
                        else
                        begin
                            last = last_elem();
                            put(KIND_NIL, 8'd0, -acc, 1, last, ERR_NONE);
                            step_on(last);
                        end
                    end
                    else if (acc > cap_of(lim_bulk))
                        abort(ERR_RANGE);
                    else
                    begin
                        bulk_left = acc[31:0]; ph = PH_BDATA; saw_cr = 0; held_v = 0;
                        put(KIND_BLEN, 8'd0, acc, 0, 0, ERR_NONE);
                    end
                end
            end
            PH_ALEN:
            begin
                r = digit_in(b);
                if (r > 0)
                    abort(r[1:0]);
                else if (r == 0)
                begin
                    if (neg)
                    begin
                        if (acc != 1)
                            abort(ERR_RANGE);
                        else
                        begin
                            put(KIND_ACNT, 8'd0, -acc, 0, 1, ERR_NONE);
                            finish_it();
                        end
                    end
                    else if (acc > cap_of(lim_elem))
                        abort(ERR_RANGE);
                    else if (acc == 0)
                    begin
                        put(KIND_ACNT, 8'd0, 64'd0, 0, 1, ERR_NONE);
                        finish_it();
                    end
                    else
                    begin
                        put(KIND_ACNT, 8'd0, acc, 0, 0, ERR_NONE);
                        elem_total = acc[31:0]; elem_done = 0; in_arr = 1; ph = PH_ETYPE;
                    end
                end
            end
            PH_BDATA:
            begin
                if (bulk_left > 0)
                begin
                    bulk_left--;
                    if (held_v)
                        put(KIND_ELEM, held_b, 64'd1, 0, 0, ERR_NONE);
                    held_b = b; held_v = 1;
                end
                else if (!saw_cr)
                begin
                    if (b != CH_CR)
                        abort(ERR_SYNTAX);
                    else
                        saw_cr = 1;
                end
                else if (b != CH_LF)
                    abort(ERR_SYNTAX);
                else
                    close_item(KIND_ELEM);
            end
            PH_ETYPE:
            begin
                if (b == CH_DOLLAR)
                    start_number(PH_BLEN);
                else if (b == CH_MINUS || b == CH_PLUS || b == CH_COLON)
                begin
                    ph = PH_ELINE; saw_cr = 0; held_b = b; held_v = 1;
                end
                else
                    abort(ERR_TYPE);
            end
            default: ;
        endcase
        if (got)
            parsed_q = {parsed_q, res};
    endtask

    assign pending = parsed_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            lim_bulk <= 31'd536870912;
            lim_elem <= 31'h7FFF_FFFF;
            clear_state();
            parsed_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == IDX_MAX_BULK)
                    lim_bulk <= cfg_data;
                else
                    lim_elem <= cfg_data;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (parsed_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", out_ch.data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = parsed_q.pop_front();
                    if (want !== out_ch.data)
                    begin
                        if (fail_count < 10)
                        begin
                            $write("mismatch: exp k%0d t%0d p%h n%0d i%0d e%b d%b c%0d",
                                want.kind, want.reply_type, want.payload_byte,
                                $signed(want.number), want.element_index, want.element_end,
                                want.reply_done, want.error_code);
                            $display(", act k%0d t%0d p%h n%0d i%0d e%b d%b c%0d",
                                out_ch.data.kind, out_ch.data.reply_type,
                                out_ch.data.payload_byte, $signed(out_ch.data.number),
                                out_ch.data.element_index, out_ch.data.element_end,
                                out_ch.data.reply_done, out_ch.data.error_code);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                parse_byte(in_ch.data);
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import rrp_pkg::*;

    logic        clk, rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [30:0] cfg_data;
    int          fail_count, pending;
    int          sent, cycles;
    int          idle_pct, stall_pct;
    byte_t       msg[$];

    rrp_in_if  in_ch();
    rrp_out_if out_ch();

    resp_reply_parser_unit dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rrp_checker chk (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic add(logic [7:0] b, logic s = 0);
        byte_t t;
        t.data_byte = b; t.start_of_reply = s;
        msg = {msg, t};
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add(s[i]);
    endtask

    task automatic add_num(longint v);
        add_str($sformatf("%0d", v));
    endtask

    task automatic add_line_body();
        int n;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
            add(8'($urandom_range(32, 126)));
        add(CH_CR); add(CH_LF);
    endtask

    task automatic add_bulk_elem();
        int n;
        n = $urandom_range(8);
        if ($urandom_range(9) == 0)
        begin
            add_str("$-1\r\n");
            return;
        end
        add(CH_DOLLAR); add_num(64'(n)); add(CH_CR); add(CH_LF);
        for (int i = 0; i < n; i++)
            add(8'($urandom_range(255)));
        add(CH_CR); add(CH_LF);
    endtask

    task automatic gen_reply();
        int k, n;
        k = $urandom_range(19);
        case (k)
            0, 1, 2: begin add($urandom_range(1) ? CH_MINUS : CH_PLUS, 1); add_line_body(); end
            3, 4:
            begin
                add(CH_COLON, 1);
                case ($urandom_range(3))
                    0: add_num($signed({$urandom, $urandom}));
                    1: add_num(-$signed(64'($urandom_range(1000))));
                    default: add_num(64'($urandom_range(99999)));
                endcase
                add(CH_CR); add(CH_LF);
            end
            5, 6, 7:
            begin
                n = msg.size();
                add_bulk_elem();
                msg[n].start_of_reply = 1'b1;
            end
            8, 9, 10, 11, 12:
            begin
                n = $urandom_range(5);
                add(CH_STAR, 1); add_num(64'(n)); add(CH_CR); add(CH_LF);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(3))
                        0: begin add(CH_PLUS); add_line_body(); end
                        1: begin add(CH_COLON); add_num(64'($urandom_range(999))); add(CH_CR);
                            add(CH_LF); end
                        default: add_bulk_elem();
                    endcase
                end
            end
            13: begin add(CH_STAR, 1); add_str("-1\r\n"); end
            default:
            begin
                add(8'($urandom_range(255)), 1);
                n = $urandom_range(8);
                for (int i = 0; i < n; i++)
                    add($urandom_range(3) == 0 ? 8'($urandom_range(255))
                        : ($urandom_range(1) ? CH_CR : 8'($urandom_range(48, 57))));
            end
        endcase
    endtask

    task automatic send_all();
        while (msg.size() > 0)
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                in_ch.valid <= 0;
                @(negedge clk);
            end
            else
            begin
                in_ch.valid <= 1;
                in_ch.data <= msg[0];
                @(posedge clk);
                while (!in_ch.ready)
                    @(posedge clk);
                void'(msg.pop_front());
                sent++;
                @(negedge clk);
                if (msg.size() == 0)
                    in_ch.valid <= 0;
            end
        end
        in_ch.valid <= 0;
    endtask

    task automatic drain();
        while (pending > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_reg(logic [0:0] idx, logic [30:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    initial
    begin
        rst_n = 0; cfg_we = 0; cfg_index = IDX_MAX_BULK; cfg_data = 0;
        in_ch.valid = 0; in_ch.data = '0;
        idle_pct = 0; stall_pct = 0; sent = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed replies
        add(CH_PLUS, 1); add_str("OK\r\n");
        add(CH_MINUS, 1); add_str("\r\n");
        add(CH_COLON, 1); add_str("-9223372036854775808\r\n");
        add(CH_COLON, 1); add_str("9223372036854775808\r\n");
        add(CH_DOLLAR, 1); add_str("-1\r\n");
        add(CH_DOLLAR, 1); add_str("0\r\n\r\n");
        add(CH_STAR, 1); add_str("0\r\n");
        add(CH_STAR, 1); add_str("3\r\n$2\r\n"); add(8'hFF); add(8'h00);
        add_str("\r\n$-1\r\n:7\r\n");
        add(CH_STAR, 1); add_str("1\r\n*0\r\n");
        add(8'h41, 1);
        add(CH_COLON, 1); add_str("\r\n");
        add(CH_COLON, 1); add_str("1-\r\n");
        add(CH_DOLLAR, 1); add_str("-2\r\n");
        add(CH_PLUS, 1); add_str("a\rb");
        add(CH_PLUS, 1); add_str("a\nb");
        add(CH_DOLLAR, 1); add_str("1\r\nxy");
        send_all();
        drain();

        set_reg(IDX_MAX_BULK, 31'd0);
        set_reg(IDX_MAX_ELEM, 31'd0);
        add(CH_DOLLAR, 1); add_str("1\r\nx\r\n");
        add(CH_DOLLAR, 1); add_str("0\r\n\r\n");
        add(CH_STAR, 1); add_str("1\r\n");
        send_all();
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0; stall_pct = 0; set_reg(IDX_MAX_BULK, 31'h7FFF_FFFF);
                    set_reg(IDX_MAX_ELEM, 31'h7FFF_FFFF); end
                1: begin idle_pct = 51; stall_pct = 0; set_reg(IDX_MAX_BULK, 31'd5);
                    set_reg(IDX_MAX_ELEM, 31'd3); end
                2: begin idle_pct = 0; stall_pct = 51; set_reg(IDX_MAX_BULK, 31'd536870912);
                    set_reg(IDX_MAX_ELEM, 31'd4); end
                3: begin idle_pct = 22; stall_pct = 22; set_reg(IDX_MAX_BULK, 31'd8);
                    set_reg(IDX_MAX_ELEM, 31'h7FFF_FFFF); end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            while (msg.size() < 320)
                gen_reply();
            send_all();
            if (phase == 2)
            begin
                // hold off until the parser has nothing left to hand back
                while (pending > 0)
                    @(negedge clk);
            end
            drain();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
